// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and defaults for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int FUNC_W       = 2;
  localparam int KEY_W        = 31;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_OUT_W   = 6;
  localparam int COUNT_OUT_W  = 7;
  localparam int CFG_W        = 7;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_UPDATED   = 3'd1,
    RES_FOUND     = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_FULL      = 3'd4,
    RES_REMOVED   = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_OCC  = 2'd1,
    ST_DEL  = 2'd2
  } slot_st_t;

endpackage

// ===== rtl/lpht_in_if.sv =====
// ----------------------------------------------------------------------------
// lpht_in_if
// Request channel: operation code, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface lpht_in_if;

  logic                              valid;
  logic                              ready;
  logic [lpht_pkg::FUNC_W-1:0]       func;
  logic [lpht_pkg::KEY_W-1:0]        key;
  logic signed [lpht_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);

endinterface

// ===== rtl/lpht_out_if.sv =====
// ----------------------------------------------------------------------------
// lpht_out_if
// Result channel: status, slot and live-entry count with valid/ready.
// ----------------------------------------------------------------------------
interface lpht_out_if;

  logic                                valid;
  logic                                ready;
  logic [lpht_pkg::STATUS_W-1:0]       status;
  logic [lpht_pkg::SLOT_OUT_W-1:0]     slot;
  logic [lpht_pkg::COUNT_OUT_W-1:0]    live_count;

  modport source (output valid, output status, output slot, output live_count, input ready);
  modport sink   (input valid, input status, input slot, input live_count, output ready);

endinterface

// ===== rtl/lpht_mod.sv =====
// ----------------------------------------------------------------------------
// lpht_mod
// Bit-serial remainder unit: one restoring step per cycle over the key.
// ----------------------------------------------------------------------------
module lpht_mod #(
  parameter int KEY_W = lpht_pkg::KEY_W,
  parameter int DIV_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = (KEY_W > 1) ? $clog2(KEY_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0] shf_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W:0]   trial;

  // shift in the next key bit, subtract the divisor when it fits
  always_comb begin
    trial = {rem_r, shf_r[KEY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(KEY_W - 1);
        rem_r  <= '0;
        shf_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        shf_r <= shf_r << 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and deletion marks.
// ----------------------------------------------------------------------------
// Each item runs the hash, then probes 1 .. table size slots; an unused
//   operation code skips both and goes straight to the finish step.
// Throughput: one item at a time, no new item until the last has finished;
//   the serial remainder unit (one key bit a cycle) and the probe loop
//   through the registered slot-state/key memory read port set the pace.
// Reset: synchronous, active low. A clearing pass then marks every slot
//   free, with in_ch.ready low; config writes are taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_wdata,
  lpht_in_if.sink                    in_ch,
  lpht_out_if.source                 out_ch
);

  localparam int SW = $clog2(SLOTS);       // slot index width
  localparam int CW = $clog2(SLOTS + 1);   // count / size width

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [lpht_pkg::CFG_W-1:0] table_size_r;
  logic [CW-1:0]              size_use;

  // per-item context
  logic [SW-1:0]                     clr_addr_r;
  logic [lpht_pkg::FUNC_W-1:0]       func_r;
  logic [lpht_pkg::KEY_W-1:0]        key_r;
  logic [lpht_pkg::VALUE_W-1:0]      value_r;
  logic [CW-1:0]                     size_r;
  logic [SW-1:0]                     home_r;
  logic [SW-1:0]                     h_r;
  logic                              found_r;
  logic                              free_vld_r;
  logic [SW-1:0]                     free_slot_r;
  logic [CW-1:0]                     count_r;

  // result register
  logic                              out_valid_r;
  logic [lpht_pkg::STATUS_W-1:0]     out_status_r;
  logic [lpht_pkg::SLOT_OUT_W-1:0]   out_slot_r;
  logic [lpht_pkg::COUNT_OUT_W-1:0]  out_count_r;

  // memories
  lpht_pkg::slot_st_t                st_mem [SLOTS];
  logic [lpht_pkg::KEY_W-1:0]        key_mem [SLOTS];
  logic [lpht_pkg::VALUE_W-1:0]      data_mem [SLOTS];
  lpht_pkg::slot_st_t                rd_st_r;
  logic [lpht_pkg::KEY_W-1:0]        rd_key_r;

  // remainder unit
  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  // probe and finish decode
  logic               in_xfer;
  logic               fin_go;
  logic [CW-1:0]      h_inc;
  logic [SW-1:0]      h_nxt;
  logic               h_wrap;
  logic               fin_st_we;
  lpht_pkg::slot_st_t fin_st_val;
  logic               fin_key_we;
  logic               fin_data_we;
  logic [SW-1:0]      fin_addr;
  logic [lpht_pkg::STATUS_W-1:0] fin_status;
  logic [SW-1:0]      fin_slot;
  logic [CW-1:0]      count_nxt;
  logic               st_we;
  logic [SW-1:0]      st_waddr;
  lpht_pkg::slot_st_t st_wval;

  // --------------------------------------------------------------------------
  // Configuration: table size, clamped to 1 .. SLOTS when an item starts.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= lpht_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (table_size_r == '0) begin
      size_use = CW'(1);
    end else if (int'(table_size_r) > SLOTS) begin
      size_use = CW'(SLOTS);
    end else begin
      size_use = CW'(table_size_r);
    end
  end

  // --------------------------------------------------------------------------
  // Home slot: key mod size, one key bit per cycle.
  // --------------------------------------------------------------------------
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign mod_start = in_xfer;

  lpht_mod #(
    .KEY_W (lpht_pkg::KEY_W),
    .DIV_W (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .divisor  (size_use),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // --------------------------------------------------------------------------
  // Probe step: next slot wraps at the table size; back at home means the
  // whole table has been walked.
  // --------------------------------------------------------------------------
  always_comb begin
    h_inc  = CW'(h_r) + CW'(1);
    h_nxt  = (h_inc == size_r) ? '0 : h_inc[SW-1:0];
    h_wrap = (h_nxt == home_r);
  end

  // --------------------------------------------------------------------------
  // Finish decode. The probe walk both looks for the key and remembers the
  // first slot that is not occupied; a new key goes there, which is the same
  // slot a second walk from home would pick.
  // --------------------------------------------------------------------------
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    fin_st_we   = 1'b0;
    fin_st_val  = lpht_pkg::ST_OCC;
    fin_key_we  = 1'b0;
    fin_data_we = 1'b0;
    fin_addr    = h_r;
    fin_status  = lpht_pkg::RES_NOT_FOUND;
    fin_slot    = '0;
    count_nxt   = count_r;
    case (func_r)
      lpht_pkg::FN_INSERT: begin
        if (found_r) begin
          fin_data_we = 1'b1;
          fin_status  = lpht_pkg::RES_UPDATED;
          fin_slot    = h_r;
        end else if (free_vld_r) begin
          fin_addr    = free_slot_r;
          fin_st_we   = 1'b1;
          fin_st_val  = lpht_pkg::ST_OCC;
          fin_key_we  = 1'b1;
          fin_data_we = 1'b1;
          fin_status  = lpht_pkg::RES_INSERTED;
          fin_slot    = free_slot_r;
          count_nxt   = count_r + 1'b1;
        end else begin
          fin_status  = lpht_pkg::RES_FULL;
        end
      end
      lpht_pkg::FN_SEARCH: begin
        if (found_r) begin
          fin_status = lpht_pkg::RES_FOUND;
          fin_slot   = h_r;
        end
      end
      lpht_pkg::FN_REMOVE: begin
        if (found_r) begin
          fin_st_we  = 1'b1;
          fin_st_val = lpht_pkg::ST_DEL;
          fin_status = lpht_pkg::RES_REMOVED;
          fin_slot   = h_r;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        fin_status = lpht_pkg::RES_NOT_FOUND;
      end
    endcase
  end

  // state write port: clearing pass after reset, else the finish step
  always_comb begin
    if (state_r == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_addr_r;
      st_wval  = lpht_pkg::ST_FREE;
    end else begin
      st_we    = fin_go && fin_st_we;
      st_waddr = fin_addr;
      st_wval  = fin_st_val;
    end
  end

  // --------------------------------------------------------------------------
  // Slot memories: one write and one registered read a cycle. The read
  // address is always the current probe slot.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wval;
    end
    rd_st_r <= st_mem[h_r];
  end

  always_ff @(posedge clk) begin
    if (fin_go && fin_key_we) begin
      key_mem[fin_addr] <= key_r;
    end
    rd_key_r <= key_mem[h_r];
  end

  // value store; no operation reads a value back
  always_ff @(posedge clk) begin
    if (fin_go && fin_data_we) begin
      data_mem[fin_addr] <= value_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      // drop the result once the sink takes the transfer, unless a new one
      // is loaded in the same cycle
      if (out_valid_r && out_ch.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == SW'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            func_r     <= in_ch.func;
            key_r      <= in_ch.key;
            value_r    <= in_ch.value;
            size_r     <= size_use;
            found_r    <= 1'b0;
            free_vld_r <= 1'b0;
            if (in_ch.func == lpht_pkg::FN_INSERT || in_ch.func == lpht_pkg::FN_SEARCH ||
                in_ch.func == lpht_pkg::FN_REMOVE) begin
              state_r <= S_HASH;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            home_r  <= mod_rem[SW-1:0];
            h_r     <= mod_rem[SW-1:0];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // wait out the registered memory read
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_st_r != lpht_pkg::ST_OCC && !free_vld_r) begin
            free_vld_r  <= 1'b1;
            free_slot_r <= h_r;
          end
          if (rd_st_r == lpht_pkg::ST_FREE) begin
            state_r <= S_FIN;
          end else if (rd_st_r == lpht_pkg::ST_OCC && rd_key_r == key_r) begin
            found_r <= 1'b1;
            state_r <= S_FIN;
          end else if (h_wrap) begin
            state_r <= S_FIN;
          end else begin
            h_r     <= h_nxt;
            state_r <= S_READ;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            count_r      <= count_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= fin_status;
            out_slot_r   <= lpht_pkg::SLOT_OUT_W'(fin_slot);
            out_count_r  <= lpht_pkg::COUNT_OUT_W'(count_nxt);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.live_count = out_count_r;

endmodule

// ===== verif/tb_linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_top
// Self-checking bench for the linear-probing hash table. A directed table of
// operations hits the corner cases at full size. Random phases then run
// insert, search and remove over key pools at a range of table sizes. A
// behavioral copy of the table predicts status, slot and live count for each
// accepted operation. Results are checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_top;

  localparam int SLOTS          = lpht_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int RX_HOLD_CYCLES = 600;
  // tail wait after the final drain, covering the worst probe chain
  localparam int TAIL_CYCLES    = 200;
  localparam int CFG_PAUSE      = 4;
  localparam int N_DIRECTED     = 19;
  localparam int N_PHASES       = 15;
  localparam logic [lpht_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [lpht_pkg::STATUS_W-1:0]    status;
    logic [lpht_pkg::SLOT_OUT_W-1:0]  slot;
    logic [lpht_pkg::COUNT_OUT_W-1:0] live;
  } table_res_t;

  // one directed operation; when fixed is set the result below is expected
  // as written, otherwise the table copy supplies it
  typedef struct packed {
    logic [lpht_pkg::FUNC_W-1:0]      func;
    logic [lpht_pkg::KEY_W-1:0]       key;
    logic [lpht_pkg::VALUE_W-1:0]     value;
    logic                             fixed;
    logic [lpht_pkg::STATUS_W-1:0]    status;
    logic [lpht_pkg::SLOT_OUT_W-1:0]  slot;
    logic [lpht_pkg::COUNT_OUT_W-1:0] live;
  } dir_op_t;

  // one random phase: size register value, operation count, key pool size,
  // insert and remove shares in percent (search and unused codes share the rest)
  typedef struct packed {
    logic [lpht_pkg::CFG_W-1:0] size;
    int unsigned                ops;
    int unsigned                pool;
    int unsigned                ins_pct;
    int unsigned                rem_pct;
  } phase_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [lpht_pkg::CFG_W-1:0] cfg_wdata;

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table_top #(.SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // table copy used for prediction
  lpht_pkg::slot_st_t         tbl_state [SLOTS];
  logic [lpht_pkg::KEY_W-1:0] tbl_key   [SLOTS];
  int                         tbl_live;
  logic [lpht_pkg::CFG_W-1:0] tbl_size;

  table_res_t                 result_q [$];
  int                         err_cnt;
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         hold_reqs;

  dir_op_t                    dir_ops [N_DIRECTED];
  phase_t                     phases  [N_PHASES];
  logic [lpht_pkg::KEY_W-1:0] key_pool [128];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the drain never completes.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_linear_probe_hash_table_top NOT OK");
    $finish;
  end

  // Result sink: drive ready at the falling edge. A new hold request from the
  // stimulus side drops ready for a long stretch so the block backs up.
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic cmp_field(input string what, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    table_res_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing pending, status %0d slot %0d live %0d",
                 $time, out_ch.status, out_ch.slot, out_ch.live_count);
      end else begin
        due = result_q.pop_front();
        cmp_field("status", due.status, out_ch.status);
        cmp_field("slot", due.slot, out_ch.slot);
        cmp_field("live_count", due.live, out_ch.live_count);
      end
    end
  end

  // Walk the probe chain from the home slot: hit index, or -1 on a free slot
  // or a full wrap. Deleted slots are stepped over.
  function automatic int probe_key(input logic [lpht_pkg::KEY_W-1:0] k, input int span);
    int home;
    int h;
    home = int'({1'b0, k} % span);
    h = home;
    forever begin
      if (tbl_state[h] == lpht_pkg::ST_FREE) return -1;
      if (tbl_state[h] == lpht_pkg::ST_OCC && tbl_key[h] == k) return h;
      h = (h + 1) % span;
      if (h == home) return -1;
    end
  endfunction

  // Apply one operation to the table copy and return what the block reports.
  task automatic table_apply(input logic [lpht_pkg::FUNC_W-1:0] f,
                             input logic [lpht_pkg::KEY_W-1:0] k,
                             output table_res_t r);
    int span;
    int hit;
    int home;
    int h;
    bit full;
    span = (tbl_size == 0) ? 1 : ((tbl_size > SLOTS) ? SLOTS : int'(tbl_size));
    r.status = lpht_pkg::RES_NOT_FOUND;
    r.slot = '0;
    hit = -1;
    if (f == lpht_pkg::FN_INSERT || f == lpht_pkg::FN_SEARCH || f == lpht_pkg::FN_REMOVE)
      hit = probe_key(k, span);
    case (f)
      lpht_pkg::FN_INSERT: begin
        if (hit >= 0) begin
          r.status = lpht_pkg::RES_UPDATED;
          r.slot = hit[lpht_pkg::SLOT_OUT_W-1:0];
        end else begin
          // first slot that is not occupied; deleted slots are reused
          home = int'({1'b0, k} % span);
          h = home;
          full = 1'b0;
          while (tbl_state[h] == lpht_pkg::ST_OCC) begin
            h = (h + 1) % span;
            if (h == home) begin
              full = 1'b1;
              break;
            end
          end
          if (full) begin
            r.status = lpht_pkg::RES_FULL;
          end else begin
            tbl_state[h] = lpht_pkg::ST_OCC;
            tbl_key[h] = k;
            tbl_live++;
            r.status = lpht_pkg::RES_INSERTED;
            r.slot = h[lpht_pkg::SLOT_OUT_W-1:0];
          end
        end
      end
      lpht_pkg::FN_SEARCH: begin
        if (hit >= 0) begin
          r.status = lpht_pkg::RES_FOUND;
          r.slot = hit[lpht_pkg::SLOT_OUT_W-1:0];
        end
      end
      lpht_pkg::FN_REMOVE: begin
        if (hit >= 0) begin
          tbl_state[hit] = lpht_pkg::ST_DEL;
          if (tbl_live > 0) tbl_live--;
          r.status = lpht_pkg::RES_REMOVED;
          r.slot = hit[lpht_pkg::SLOT_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    r.live = tbl_live[lpht_pkg::COUNT_OUT_W-1:0];
  endtask

  // Offer one operation after a random gap; predict it once it transfers.
  // Enter and leave at a falling edge with valid untouched in that step.
  task automatic send_op(input logic [lpht_pkg::FUNC_W-1:0] f,
                         input logic [lpht_pkg::KEY_W-1:0] k,
                         input logic [lpht_pkg::VALUE_W-1:0] v, input logic fixed,
                         input table_res_t fixed_res);
    table_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.key   <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_apply(f, k, r);
    result_q.push_back(fixed ? fixed_res : r);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (result_q.size() != 0);
  endtask

  task automatic write_size(input logic [lpht_pkg::CFG_W-1:0] v);
    drain();
    repeat (CFG_PAUSE) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tbl_size = v;
  endtask

  initial begin
    table_res_t                  fr;
    table_res_t                  none;
    logic [31:0]                 w;
    logic [lpht_pkg::KEY_W-1:0]  k;
    logic [lpht_pkg::FUNC_W-1:0] f;
    int                          pick;

    // hold every input at a known value from time zero
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = '0;
    in_ch.key    = '0;
    in_ch.value  = '0;
    err_cnt      = 0;
    hold_reqs    = 0;
    tx_idle_pct  = 12;
    rx_idle_pct  = 78;
    none         = '0;
    tbl_size     = lpht_pkg::TABLE_SIZE_RST;
    tbl_live     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = lpht_pkg::ST_FREE;
      tbl_key[i]   = '0;
    end

    // Directed operations at the reset size of 64. The first rows follow
    // straight from an empty table; the rest walk collisions, wrap-around,
    // deletion marks and slot reuse and are left to the table copy.
    dir_ops = '{
      '{lpht_pkg::FN_SEARCH, 31'd5, 32'd0, 1'b1, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_REMOVE, 31'd5, 32'd0, 1'b1, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{FN_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_INSERT, 31'd0, 32'h8000_0000, 1'b1, lpht_pkg::RES_INSERTED, 6'd0,
        7'd1},
      '{lpht_pkg::FN_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, lpht_pkg::RES_INSERTED,
        6'd63, 7'd2},
      '{lpht_pkg::FN_INSERT, 31'd64, 32'hFFFF_FFFF, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0,
        7'd0},
      '{lpht_pkg::FN_INSERT, 31'd127, 32'd1, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_INSERT, 31'd0, 32'd5, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_SEARCH, 31'd64, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_REMOVE, 31'd64, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_SEARCH, 31'd127, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_SEARCH, 31'd128, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_INSERT, 31'd128, 32'h1234_5678, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0,
        7'd0},
      '{lpht_pkg::FN_REMOVE, 31'h7FFF_FFFF, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0,
        7'd0},
      '{lpht_pkg::FN_REMOVE, 31'h7FFF_FFFF, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0,
        7'd0},
      '{FN_UNUSED, 31'd0, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0, 7'd0},
      '{lpht_pkg::FN_INSERT, 31'h5555_5555, 32'h5555_5555, 1'b0, lpht_pkg::RES_NOT_FOUND,
        6'd0, 7'd0},
      '{lpht_pkg::FN_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 1'b0, lpht_pkg::RES_NOT_FOUND,
        6'd0, 7'd0},
      '{lpht_pkg::FN_SEARCH, 31'h2AAA_AAAA, 32'd0, 1'b0, lpht_pkg::RES_NOT_FOUND, 6'd0,
        7'd0}
    };

    // Random phases. Entries carry over between phases, so shrinking the
    // size strands entries beyond it; zero and oversize values get clamped.
    phases = '{
      '{7'd1,   40,  4,  50, 25},
      '{7'd0,   30,  3,  50, 25},
      '{7'd127, 80,  24, 50, 25},
      '{7'd2,   60,  6,  45, 25},
      '{7'd5,   100, 10, 45, 25},
      '{7'd13,  120, 20, 45, 25},
      '{7'd64,  200, 90, 85, 5},
      '{7'd3,   80,  6,  45, 30},
      '{7'd64,  120, 40, 30, 45},
      '{7'd8,   120, 12, 45, 25},
      '{7'd31,  120, 40, 45, 25},
      '{7'd65,  100, 30, 50, 25},
      '{7'd16,  100, 24, 45, 25},
      '{7'd4,   80,  8,  45, 25},
      '{7'd40,  80,  50, 50, 20}
    };

    // hold reset low, then release it; the block then clears its slots with
    // input ready low, which the first transfer simply waits out
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      fr = '{dir_ops[i].status, dir_ops[i].slot, dir_ops[i].live};
      send_op(dir_ops[i].func, dir_ops[i].key, dir_ops[i].value, dir_ops[i].fixed, fr);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // sender busy, receiver slow first; then the reverse; then full rate
      tx_idle_pct = (p < 5) ? 12 : ((p < 10) ? 78 : 0);
      rx_idle_pct = (p < 5) ? 78 : ((p < 10) ? 12 : 0);
      write_size(phases[p].size);

      // build the key pool: mostly full-width keys, some small ones so
      // that home slots pile up at every table size
      for (int j = 0; j < phases[p].pool; j++) begin
        w = ($urandom_range(3) == 0) ? 32'($urandom_range(200)) : $urandom;
        key_pool[j] = w[lpht_pkg::KEY_W-1:0];
      end

      for (int i = 0; i < phases[p].ops; i++) begin
        // back up the block once with the receiver held off
        if (p == 10 && i == 20) hold_reqs++;
        // let everything drain mid-phase once
        if (p == 12 && i == 50) drain();

        w = $urandom;
        k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(phases[p].pool - 1)]
                                    : w[lpht_pkg::KEY_W-1:0];
        pick = $urandom_range(99);
        if (pick < phases[p].ins_pct) f = lpht_pkg::FN_INSERT;
        else if (pick < phases[p].ins_pct + phases[p].rem_pct) f = lpht_pkg::FN_REMOVE;
        else if (pick < 95) f = lpht_pkg::FN_SEARCH;
        else f = FN_UNUSED;
        send_op(f, k, $urandom, 1'b0, none);
      end
    end

    // wait out all pending results, then watch for stray ones
    rx_idle_pct = 0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, result_q.size());
    end

    if (err_cnt == 0) begin
      $display("tb_linear_probe_hash_table_top OK");
    end else begin
      $display("tb_linear_probe_hash_table_top NOT OK");
    end
    $finish;
  end

endmodule
